// ----- rtl/sliding_window_packet_buffer_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the packet buffer
// Concurrent checks that are compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_PACKET_BUFFER_ASSERT_SVH
`define SLIDING_WINDOW_PACKET_BUFFER_ASSERT_SVH
`ifndef SYNTHESIS
`define SWPB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define SWPB_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define SWPB_ASSERT(lbl, prop, msg)
`define SWPB_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ----- rtl/swpb_pkg.sv -----
// ----------------------------------------------------------------------------
// swpb_pkg
// Types, codes and helpers shared by the packet buffer modules.
// ----------------------------------------------------------------------------
package swpb_pkg;

   localparam logic [2:0] ACT_STORE   = 3'd0;
   localparam logic [2:0] ACT_READ    = 3'd1;
   localparam logic [2:0] ACT_FLUSH   = 3'd2;
   localparam logic [2:0] ACT_ACK     = 3'd3;
   localparam logic [2:0] ACT_ADVANCE = 3'd4;

   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_TOO_LONG  = 2'd1;
   localparam logic [1:0] STS_OCCUPIED  = 2'd2;
   localparam logic [1:0] STS_NOT_FOUND = 2'd3;

   localparam int FLUSH_MAX = 16;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MOD, ST_META, ST_CHK, ST_RDOUT, ST_FLCHK, ST_FLLAST, ST_ACK
   } state_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] seq;
      logic [6:0]  word_index;
      logic [63:0] data_word;
      logic [15:0] length;
      logic [63:0] header_in;
      logic        last_word;
      logic [31:0] expected_seq;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] data_out;
      logic [63:0] header_out;
      logic [15:0] length_out;
      logic [31:0] released_seq;
      logic [3:0]  released_slot;
      logic [31:0] expected_seq_out;
      logic        window_full;
      logic [31:0] lowest_unacked;
      logic [31:0] next_seq;
      logic        seq_in_window;
      logic        last_result;
   } rsp_type;

   typedef struct packed {
      logic [31:0] seq;
      logic [15:0] length;
      logic [63:0] header;
   } meta_type;

   // zero the bytes at or past the packet length
   function automatic logic [63:0] keep_bytes(logic [63:0] word, logic [6:0] idx,
                                              logic [15:0] len);
      logic [15:0] start;
      logic [15:0] rem;
      logic [63:0] mask;
      start = {6'd0, idx, 3'd0};
      rem   = len - start;
      mask  = (64'd1 << {rem[2:0], 3'd0}) - 64'd1;
      if (start >= len) begin
         return 64'd0;
      end else if (rem >= 16'd8) begin
         return word;
      end else begin
         return word & mask;
      end
   endfunction

endpackage

// ----- rtl/swpb_mod.sv -----
// ----------------------------------------------------------------------------
// swpb_mod
// Restoring remainder unit: 32-bit value modulo the window size, one bit a cycle.
// ----------------------------------------------------------------------------
module swpb_mod #(
   parameter int CNT_W = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [31:0]      dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic             done,
   output logic [CNT_W-1:0] remainder
);
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [4:0]       bit_ff, bit_in;
   logic [31:0]      dvd_ff, dvd_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [CNT_W:0]   trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         bit_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         bit_ff  <= bit_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      bit_in  = bit_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, dvd_ff[31]};
      if (start) begin
         run_in = 1'b1;
         bit_in = '0;
         dvd_in = dividend;
         rem_in = '0;
      end else if (run_ff) begin
         if (trial >= {1'b0, divisor}) begin
            trial = trial - {1'b0, divisor};
         end
         rem_in = trial[CNT_W-1:0];
         dvd_in = {dvd_ff[30:0], 1'b0};
         bit_in = bit_ff + 5'd1;
         if (bit_ff == 5'd31) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule

// ----- rtl/swpb_store.sv -----
// ----------------------------------------------------------------------------
// swpb_store
// Slot metadata memory and payload memory, one shared read/write port each.
// ----------------------------------------------------------------------------
module swpb_store #(
   parameter int SLOT_W = 4,
   parameter int SLOTS  = 16,
   parameter int ADDR_W = 11,
   parameter int DEPTH  = 2048
) (
   input  logic                 clock,
   input  logic                 meta_we,
   input  logic [SLOT_W-1:0]    meta_addr,
   input  swpb_pkg::meta_type   meta_wdata,
   output swpb_pkg::meta_type   meta_rdata,
   input  logic                 pay_we,
   input  logic [ADDR_W-1:0]    pay_addr,
   input  logic [63:0]          pay_wdata,
   output logic [63:0]          pay_rdata
);
   import swpb_pkg::*;

   meta_type    meta_mem [SLOTS];
   logic [63:0] pay_mem  [DEPTH];
   meta_type    meta_rd_ff;
   logic [63:0] pay_rd_ff;

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_addr] <= meta_wdata;
      end
      meta_rd_ff <= meta_mem[meta_addr];
   end

   always_ff @(posedge clock) begin
      if (pay_we) begin
         pay_mem[pay_addr] <= pay_wdata;
      end
      pay_rd_ff <= pay_mem[pay_addr];
   end

   assign meta_rdata = meta_rd_ff;
   assign pay_rdata  = pay_rd_ff;
endmodule

// ----- rtl/sliding_window_packet_buffer.sv -----
// ----------------------------------------------------------------------------
// sliding_window_packet_buffer
// Sequence-numbered packet window with payload storage, flush and acknowledge.
// ----------------------------------------------------------------------------
// Commands enter on req_item with start; one is taken when start is high and
// busy is low. Results leave on rsp_item, each valid for the single cycle in
// which rsp_strobe is high; last_result marks the final result of a command.
// The receiver cannot stall, so results are never held back.
// Every command first takes its slot number, a sequence number modulo the
// window size, in a bit-serial remainder unit. Store and read then use
// one registered metadata read; a read also passes a read-out state for
// its payload word. Flush spends a metadata read and a check on each
// released packet, up to 16 packets, one result per packet.
// Acknowledge clears one valid bit a cycle over the acknowledged span, at
// most the window size. Advance and unknown codes finish right after the
// remainder. busy stays high until the last result has been shown, so the
// next command is taken in the cycle after that result.
// Reset clears the valid bits, next sequence number and lower window edge
// and sets the window size and upper edge to default. csr_wr_en writes the
// window size and restarts the edges; write it only while busy is low.
// ----------------------------------------------------------------------------
`include "sliding_window_packet_buffer_assert.svh"

module sliding_window_packet_buffer #(
   parameter int WINDOW_SLOTS  = 16,
   parameter int PAYLOAD_BYTES = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  swpb_pkg::req_type req_item,
   output logic              rsp_strobe,
   output swpb_pkg::rsp_type rsp_item,
   input  logic              csr_wr_en,
   input  logic [4:0]        csr_wr_data
);
   import swpb_pkg::*;

   localparam int WORDS   = (PAYLOAD_BYTES + 7) / 8;
   localparam int DEPTH   = WINDOW_SLOTS * WORDS;
   localparam int SLOT_W  = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
   localparam int CNT_W   = $clog2(WINDOW_SLOTS + 1);
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int W_RESET = (WINDOW_SLOTS < 16) ? WINDOW_SLOTS : 16;

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [CNT_W-1:0]  w_ff, w_in;
   logic [31:0]       lower_ff, lower_in;
   logic [31:0]       upper_ff, upper_in;
   logic [31:0]       nts_ff, nts_in;
   logic [WINDOW_SLOTS-1:0] valid_ff, valid_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [31:0]       cur_ff, cur_in;
   logic [3:0]        fcnt_ff, fcnt_in;
   rsp_type           pend_ff, pend_in;
   logic              pend_vld_ff, pend_vld_in;
   logic [CNT_W-1:0]  acnt_ff, acnt_in;
   logic [CNT_W-1:0]  span_ff, span_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_vld_ff, rsp_vld_in;

   logic              mod_start;
   logic [31:0]       mod_dvd;
   logic              mod_done;
   logic [CNT_W-1:0]  mod_rem;

   logic              meta_we;
   meta_type          meta_wdata;
   meta_type          meta_rdata;
   logic              pay_we;
   logic [ADDR_W-1:0] pay_addr;
   logic [63:0]       pay_wdata;
   logic [63:0]       pay_rdata;

   logic [CNT_W-1:0]  slot_inc;
   logic [SLOT_W-1:0] slot_nxt;
   logic              widx_ok;
   logic              slot_hit;
   logic [31:0]       ack_diff;
   logic [CNT_W-1:0]  w_clamp;
   logic              accept;

   swpb_mod #(.CNT_W(CNT_W)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dvd),
      .divisor   (w_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   swpb_store #(
      .SLOT_W (SLOT_W),
      .SLOTS  (WINDOW_SLOTS),
      .ADDR_W (ADDR_W),
      .DEPTH  (DEPTH)
   ) u_store (
      .clock      (clock),
      .meta_we    (meta_we),
      .meta_addr  (slot_ff),
      .meta_wdata (meta_wdata),
      .meta_rdata (meta_rdata),
      .pay_we     (pay_we),
      .pay_addr   (pay_addr),
      .pay_wdata  (pay_wdata),
      .pay_rdata  (pay_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         w_ff        <= CNT_W'(W_RESET);
         lower_ff    <= '0;
         upper_ff    <= 32'(W_RESET);
         nts_ff      <= '0;
         valid_ff    <= '0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         fcnt_ff     <= '0;
         acnt_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         w_ff        <= w_in;
         lower_ff    <= lower_in;
         upper_ff    <= upper_in;
         nts_ff      <= nts_in;
         valid_ff    <= valid_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         fcnt_ff     <= fcnt_in;
         acnt_ff     <= acnt_in;
      end
      req_ff  <= req_in;
      slot_ff <= slot_in;
      cur_ff  <= cur_in;
      pend_ff <= pend_in;
      span_ff <= span_in;
      rsp_ff  <= rsp_in;
   end

   assign accept   = start && !busy;
   assign slot_inc = CNT_W'(slot_ff) + CNT_W'(1);
   assign slot_nxt = (slot_inc == w_ff) ? '0 : SLOT_W'(slot_inc);
   assign widx_ok  = 32'(req_ff.word_index) < WORDS;
   assign pay_addr = ADDR_W'(slot_ff) * ADDR_W'(WORDS) + ADDR_W'(req_ff.word_index);
   assign ack_diff = req_ff.expected_seq - lower_ff;
   assign w_clamp  = (csr_wr_data == 5'd0) ? CNT_W'(1) :
                     (32'(csr_wr_data) > WINDOW_SLOTS) ? CNT_W'(WINDOW_SLOTS) :
                     CNT_W'(csr_wr_data);

   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      w_in        = w_ff;
      lower_in    = lower_ff;
      upper_in    = upper_ff;
      nts_in      = nts_ff;
      valid_in    = valid_ff;
      slot_in     = slot_ff;
      cur_in      = cur_ff;
      fcnt_in     = fcnt_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      acnt_in     = acnt_ff;
      span_in     = span_ff;
      rsp_in      = '0;
      rsp_vld_in  = 1'b0;
      mod_start   = 1'b0;
      mod_dvd     = req_item.seq;
      meta_we     = 1'b0;
      meta_wdata  = '{seq: req_ff.seq, length: req_ff.length, header: req_ff.header_in};
      pay_we      = 1'b0;
      pay_wdata   = keep_bytes(req_ff.data_word, req_ff.word_index, req_ff.length);
      slot_hit    = valid_ff[slot_ff] && (meta_rdata.seq == req_ff.seq);

      if (csr_wr_en) begin
         w_in     = w_clamp;
         lower_in = '0;
         upper_in = 32'(w_clamp);
         nts_in   = '0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in    = req_item;
               mod_start = 1'b1;
               case (req_item.action)
                  ACT_FLUSH: mod_dvd = req_item.expected_seq;
                  ACT_ACK:   mod_dvd = lower_ff;
                  default:   mod_dvd = req_item.seq;
               endcase
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               slot_in = SLOT_W'(mod_rem);
               case (req_ff.action)
                  ACT_STORE, ACT_READ: begin
                     state_in = ST_META;
                  end
                  ACT_FLUSH: begin
                     cur_in      = req_ff.expected_seq;
                     fcnt_in     = '0;
                     pend_vld_in = 1'b0;
                     state_in    = ST_META;
                  end
                  ACT_ACK: begin
                     if (req_ff.expected_seq > lower_ff) begin
                        acnt_in  = '0;
                        span_in  = (ack_diff > 32'(w_ff)) ? w_ff : CNT_W'(ack_diff);
                        state_in = ST_ACK;
                     end else begin
                        if (nts_ff < lower_ff) begin
                           nts_in = lower_ff;
                        end
                        rsp_in.last_result = 1'b1;
                        rsp_vld_in         = 1'b1;
                        state_in           = ST_IDLE;
                     end
                  end
                  ACT_ADVANCE: begin
                     if (req_ff.expected_seq > lower_ff) begin
                        lower_in = req_ff.expected_seq;
                        upper_in = req_ff.expected_seq + 32'(w_ff);
                     end
                     rsp_in.last_result = 1'b1;
                     rsp_vld_in         = 1'b1;
                     state_in           = ST_IDLE;
                  end
                  default: begin
                     rsp_in.last_result = 1'b1;
                     rsp_vld_in         = 1'b1;
                     state_in           = ST_IDLE;
                  end
               endcase
            end
         end
         ST_META: begin
            state_in = (req_ff.action == ACT_FLUSH) ? ST_FLCHK : ST_CHK;
         end
         ST_CHK: begin
            rsp_in.last_result = 1'b1;
            if (req_ff.action == ACT_STORE) begin
               rsp_vld_in = 1'b1;
               state_in   = ST_IDLE;
               if (32'(req_ff.length) > PAYLOAD_BYTES) begin
                  rsp_in.status = STS_TOO_LONG;
               end else if (valid_ff[slot_ff] && meta_rdata.seq != req_ff.seq) begin
                  rsp_in.status = STS_OCCUPIED;
               end else begin
                  pay_we = widx_ok;
                  if (req_ff.last_word) begin
                     meta_we           = 1'b1;
                     valid_in[slot_ff] = 1'b1;
                     if (req_ff.seq >= nts_ff) begin
                        nts_in = req_ff.seq + 32'd1;
                     end
                  end
               end
            end else if (!slot_hit) begin
               rsp_in.status = STS_NOT_FOUND;
               rsp_vld_in    = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_RDOUT;
            end
         end
         ST_RDOUT: begin
            rsp_in.data_out    = widx_ok ?
               keep_bytes(pay_rdata, req_ff.word_index, meta_rdata.length) : 64'd0;
            rsp_in.header_out  = meta_rdata.header;
            rsp_in.length_out  = meta_rdata.length;
            rsp_in.last_result = 1'b1;
            rsp_vld_in         = 1'b1;
            state_in           = ST_IDLE;
         end
         ST_FLCHK: begin
            if (valid_ff[slot_ff] && meta_rdata.seq == cur_ff) begin
               valid_in[slot_ff] = 1'b0;
               if (pend_vld_ff) begin
                  rsp_in     = pend_ff;
                  rsp_vld_in = 1'b1;
               end
               pend_in                  = '0;
               pend_in.header_out       = meta_rdata.header;
               pend_in.length_out       = meta_rdata.length;
               pend_in.released_seq     = cur_ff;
               pend_in.released_slot    = 4'(slot_ff);
               pend_in.expected_seq_out = cur_ff + 32'd1;
               pend_vld_in              = 1'b1;
               cur_in                   = cur_ff + 32'd1;
               slot_in                  = slot_nxt;
               fcnt_in                  = fcnt_ff + 4'd1;
               state_in = (32'(fcnt_ff) == FLUSH_MAX - 1) ? ST_FLLAST : ST_META;
            end else begin
               if (pend_vld_ff) begin
                  rsp_in = pend_ff;
               end else begin
                  rsp_in.status           = STS_NOT_FOUND;
                  rsp_in.expected_seq_out = req_ff.expected_seq;
               end
               rsp_in.last_result = 1'b1;
               rsp_vld_in         = 1'b1;
               pend_vld_in        = 1'b0;
               state_in           = ST_IDLE;
            end
         end
         ST_FLLAST: begin
            rsp_in             = pend_ff;
            rsp_in.last_result = 1'b1;
            rsp_vld_in         = 1'b1;
            pend_vld_in        = 1'b0;
            state_in           = ST_IDLE;
         end
         ST_ACK: begin
            valid_in[slot_ff] = 1'b0;
            slot_in           = slot_nxt;
            acnt_in           = acnt_ff + CNT_W'(1);
            if (acnt_ff == span_ff - CNT_W'(1)) begin
               lower_in = req_ff.expected_seq;
               if (nts_ff < req_ff.expected_seq) begin
                  nts_in = req_ff.expected_seq;
               end
               rsp_in.last_result = 1'b1;
               rsp_vld_in         = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_item                = rsp_ff;
      rsp_item.window_full    = (nts_ff - lower_ff) >= 32'(w_ff);
      rsp_item.lowest_unacked = lower_ff;
      rsp_item.next_seq       = nts_ff;
      rsp_item.seq_in_window  = (req_ff.seq >= lower_ff) && (req_ff.seq < upper_ff);
   end

   assign rsp_strobe = rsp_vld_ff;
   assign busy       = (state_ff != ST_IDLE) || rsp_vld_ff;

   `SWPB_ASSERT(a_rsp_from_work, rsp_strobe |-> ($past(state_ff) != ST_IDLE), "stray result")
   `SWPB_ASSERT(a_last_ends_item, (rsp_strobe && rsp_ff.last_result) |-> (state_ff == ST_IDLE), "early last")
   `SWPB_ASSERT_NEVER(a_win_range, (w_ff == '0) || (w_ff > CNT_W'(WINDOW_SLOTS)), "bad window")
   `SWPB_ASSERT(a_slot_range, (state_ff != ST_IDLE && state_ff != ST_MOD) |-> (CNT_W'(slot_ff) < w_ff), "bad slot")
endmodule
